@@ rtl/gpel_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gpel_pkg;

    // command codes
    localparam logic [3:0] CMD_TICK     = 4'd0;
    localparam logic [3:0] CMD_SET_OUT  = 4'd1;
    localparam logic [3:0] CMD_GET_IN   = 4'd2;
    localparam logic [3:0] CMD_GET_OUT  = 4'd3;
    localparam logic [3:0] CMD_FLAGS    = 4'd4;
    localparam logic [3:0] CMD_CAPTURE  = 4'd5;
    localparam logic [3:0] CMD_LINE_ON  = 4'd6;
    localparam logic [3:0] CMD_LINE_OFF = 4'd7;
    localparam logic [3:0] CMD_UART_SET = 4'd8;
    localparam logic [3:0] CMD_UART_CLR = 4'd9;

    // port numbers on the command word
    localparam logic [2:0] PORT_A = 3'd1;
    localparam logic [2:0] PORT_C = 3'd3;
    localparam logic [2:0] PORT_D = 3'd4;

    // stored line source codes (port number minus one)
    localparam logic [1:0] SRC_A = 2'd0;
    localparam logic [1:0] SRC_C = 2'd2;
    localparam logic [1:0] SRC_D = 2'd3;

    localparam int NPORTS = 3;

    // pins present on each port, slot 0 = A, 1 = C, 2 = D
    localparam logic [NPORTS-1:0][7:0] PORT_PINS = {8'h7D, 8'h1E, 8'h06};

    localparam int UART_SLOT     = 2;
    localparam int UART_FLAG_BIT = 6;

    // edge mode bits
    localparam int EDGE_RISE = 0;
    localparam int EDGE_FALL = 1;

    typedef logic [NPORTS-1:0] slot_oh_t;

    typedef struct packed {
        logic [3:0] cmd;
        logic [2:0] port;
        logic [7:0] pins;
        logic [7:0] value;
        logic [7:0] pads_a;
        logic [7:0] pads_c;
        logic [7:0] pads_d;
        logic [2:0] line;
        logic [1:0] trigger;
    } gpel_in_t;

    typedef struct packed {
        logic       status;
        logic [7:0] read_data;
        logic       irq_line;
        logic [7:0] drive_a;
        logic [7:0] drive_c;
        logic [7:0] drive_d;
    } gpel_out_t;

    function automatic slot_oh_t port_onehot(input logic [2:0] port);
        slot_oh_t r;
        case (port)
            PORT_A:  r = 3'b001;
            PORT_C:  r = 3'b010;
            PORT_D:  r = 3'b100;
            default: r = 3'b000;
        endcase
        return r;
    endfunction

    function automatic slot_oh_t src_onehot(input logic [1:0] code);
        slot_oh_t r;
        case (code)
            SRC_A:   r = 3'b001;
            SRC_C:   r = 3'b010;
            SRC_D:   r = 3'b100;
            default: r = 3'b000;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/gpio_expander_interrupt_latch_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir   Handshake           Word
// s_        in    s_valid / s_ready   s_data  (gpel_pkg::gpel_in_t)
// m_        out   m_valid / m_ready   m_data  (gpel_pkg::gpel_out_t)
// cfg_      in    cfg_wr_en           cfg_wr_data (irq polarity)
//
// One word per cycle sustained while m_ready stays high; a result is offered once its word has
// passed the input register and the single-pass update into the result register.
// Reset is synchronous on aresetn low; flags, enables, latches cleared, IRQ active high.
// A stalled m_ready holds the result register; one more word waits in the input register
// and s_ready drops only when both are full.

module gpio_expander_interrupt_latch_core #(
    parameter int LINE_COUNT = 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire gpel_pkg::gpel_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output gpel_pkg::gpel_out_t      m_data,
    input  wire logic                cfg_wr_en,
    input  wire logic                cfg_wr_data
);

    localparam int LINES = (LINE_COUNT < 8) ? LINE_COUNT : 8;

    logic                in_valid_reg;
    gpel_pkg::gpel_in_t  in_word_reg;
    logic                out_valid_reg;
    gpel_pkg::gpel_out_t out_word_reg;
    gpel_pkg::gpel_out_t exec_result;
    logic                advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

    gpel_exec #(
        .LINES(LINES)
    ) u_exec (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .exec_en    (advance),
        .item       (in_word_reg),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .result     (exec_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
        if (advance) begin
            out_word_reg <= exec_result;
        end
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |-> !advance)
        else $error("result register overwritten while stalled");

    a_advance_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("executed word not presented");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result word dropped or changed");

endmodule

`default_nettype wire

@@ rtl/gpel_exec.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gpel_exec #(
    parameter int LINES = 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                exec_en,
    input  wire gpel_pkg::gpel_in_t  item,
    input  wire logic                cfg_wr_en,
    input  wire logic                cfg_wr_data,
    output gpel_pkg::gpel_out_t      result
);

    localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;
    localparam logic [LINES-1:0][1:0] MODE_RESET = {LINES{2'b01}};

    logic [gpel_pkg::NPORTS-1:0][7:0] prev_reg, prev_next;
    logic [gpel_pkg::NPORTS-1:0][7:0] out_reg, out_next;
    logic [gpel_pkg::NPORTS-1:0][7:0] flags_reg, flags_next;
    logic [gpel_pkg::NPORTS-1:0][7:0] cap_reg, cap_next;
    logic [LINES-1:0]                 en_reg, en_next;
    logic [LINES-1:0][1:0]            src_reg, src_next;
    logic [LINES-1:0][1:0]            mode_reg, mode_next;
    logic                             irq_high_reg;

    logic [gpel_pkg::NPORTS-1:0][7:0] pads;
    logic [LINES-1:0][gpel_pkg::NPORTS-1:0] src_oh;
    gpel_pkg::slot_oh_t slot_oh;
    gpel_pkg::slot_oh_t line_src_oh;
    logic       needs_port;
    logic       bad_port;
    logic       line_ok;
    logic [7:0] m;
    logic [7:0] sel_pads;
    logic [7:0] sel_flags;
    logic [7:0] sel_out;
    logic [7:0] sel_cap;
    logic [7:0] hit;
    logic [7:0] rd;
    logic [7:0] line_bit;
    logic [IDX_W-1:0] idx;
    logic       prev_b;
    logic       cur_b;
    logic       edge_hit;

    always_comb begin
        pads       = {item.pads_d, item.pads_c, item.pads_a};
        slot_oh    = gpel_pkg::port_onehot(item.port);
        needs_port = (item.cmd >= gpel_pkg::CMD_SET_OUT) && (item.cmd <= gpel_pkg::CMD_LINE_OFF);
        bad_port   = needs_port && (slot_oh == '0);

        m         = '0;
        sel_pads  = '0;
        sel_flags = '0;
        sel_out   = '0;
        sel_cap   = '0;
        for (int p = 0; p < gpel_pkg::NPORTS; p++) begin
            if (slot_oh[p]) begin
                m         = item.pins & gpel_pkg::PORT_PINS[p];
                sel_pads  = pads[p];
                sel_flags = flags_reg[p];
                sel_out   = out_reg[p];
                sel_cap   = cap_reg[p];
            end
        end
        hit = sel_flags & m;

        for (int i = 0; i < LINES; i++) begin
            src_oh[i] = gpel_pkg::src_onehot(src_reg[i]);
        end

        line_ok     = 4'(item.line) < 4'(LINES);
        idx         = IDX_W'(item.line);
        line_bit    = 8'b1 << item.line;
        line_src_oh = src_oh[idx];

        prev_next  = prev_reg;
        out_next   = out_reg;
        flags_next = flags_reg;
        cap_next   = cap_reg;
        en_next    = en_reg;
        src_next   = src_reg;
        mode_next  = mode_reg;
        rd         = '0;
        prev_b     = 1'b0;
        cur_b      = 1'b0;
        edge_hit   = 1'b0;

        if (!bad_port) begin
            unique case (item.cmd)
                gpel_pkg::CMD_TICK: begin
                    for (int p = 0; p < gpel_pkg::NPORTS; p++) begin
                        for (int i = 0; i < LINES; i++) begin
                            prev_b   = prev_reg[p][i];
                            cur_b    = pads[p][i];
                            edge_hit = en_reg[i] && src_oh[i][p] &&
                                       ((mode_reg[i][gpel_pkg::EDGE_RISE] && !prev_b && cur_b) ||
                                        (mode_reg[i][gpel_pkg::EDGE_FALL] && prev_b && !cur_b));
                            if (edge_hit) begin
                                en_next[i] = 1'b0;
                                if (!flags_reg[p][i]) begin
                                    flags_next[p][i] = 1'b1;
                                    cap_next[p][i]   = cur_b;
                                end
                            end
                        end
                    end
                    prev_next = pads;
                end
                gpel_pkg::CMD_SET_OUT: begin
                    for (int p = 0; p < gpel_pkg::NPORTS; p++) begin
                        if (slot_oh[p]) begin
                            out_next[p] = (out_reg[p] & ~m) | (item.value & m);
                        end
                    end
                end
                gpel_pkg::CMD_GET_IN: begin
                    rd = sel_pads & m;
                    for (int p = 0; p < gpel_pkg::NPORTS; p++) begin
                        if (slot_oh[p]) begin
                            flags_next[p] = flags_reg[p] & ~m;
                        end
                    end
                    en_next = en_reg | hit[LINES-1:0];
                end
                gpel_pkg::CMD_GET_OUT: begin
                    rd = sel_out & m;
                end
                gpel_pkg::CMD_FLAGS: begin
                    rd = sel_flags;
                end
                gpel_pkg::CMD_CAPTURE: begin
                    rd      = sel_cap;
                    en_next = en_reg | sel_flags[LINES-1:0];
                    for (int p = 0; p < gpel_pkg::NPORTS; p++) begin
                        if (slot_oh[p]) begin
                            flags_next[p] = '0;
                        end
                    end
                end
                gpel_pkg::CMD_LINE_ON: begin
                    if (line_ok) begin
                        src_next[idx]  = 2'(item.port - 3'd1);
                        mode_next[idx] = item.trigger;
                        en_next[idx]   = 1'b1;
                    end
                end
                gpel_pkg::CMD_LINE_OFF: begin
                    if (line_ok && (line_src_oh == slot_oh)) begin
                        for (int p = 0; p < gpel_pkg::NPORTS; p++) begin
                            if (slot_oh[p]) begin
                                flags_next[p] = flags_reg[p] & ~line_bit;
                            end
                        end
                        en_next[idx] = 1'b0;
                    end
                end
                gpel_pkg::CMD_UART_SET: begin
                    flags_next[gpel_pkg::UART_SLOT][gpel_pkg::UART_FLAG_BIT] = 1'b1;
                end
                gpel_pkg::CMD_UART_CLR: begin
                    flags_next[gpel_pkg::UART_SLOT][gpel_pkg::UART_FLAG_BIT] = 1'b0;
                end
                default: begin
                end
            endcase
        end

        result.status    = bad_port;
        result.read_data = rd;
        result.irq_line  = (|flags_next) ? irq_high_reg : !irq_high_reg;
        result.drive_a   = out_next[0];
        result.drive_c   = out_next[1];
        result.drive_d   = out_next[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg     <= '0;
            out_reg      <= '0;
            flags_reg    <= '0;
            cap_reg      <= '0;
            en_reg       <= '0;
            src_reg      <= '0;
            mode_reg     <= MODE_RESET;
            irq_high_reg <= 1'b1;
        end else begin
            if (exec_en) begin
                prev_reg  <= prev_next;
                out_reg   <= out_next;
                flags_reg <= flags_next;
                cap_reg   <= cap_next;
                en_reg    <= en_next;
                src_reg   <= src_next;
                mode_reg  <= mode_next;
            end
            if (cfg_wr_en) begin
                irq_high_reg <= cfg_wr_data;
            end
        end
    end

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (flags_reg == '0) && (en_reg == '0))
        else $error("flags or line enables not cleared by reset");

    a_bad_port_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_en && result.status |=> $stable(flags_reg) && $stable(out_reg) && $stable(en_reg))
        else $error("state changed on invalid port word");

    a_uart_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_en && (item.cmd == gpel_pkg::CMD_UART_CLR)
        |=> !flags_reg[gpel_pkg::UART_SLOT][gpel_pkg::UART_FLAG_BIT])
        else $error("uart flag still set after clear");

endmodule

`default_nettype wire
